/* rtl/cbf_pkg.sv */
package cbf_pkg;

  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned FRAME_HEIGHT = 480;
  localparam int unsigned PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned ADDR_W       = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PIXEL_W = 3 * CHAN_W;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned COORD_W = POS_W - 1;
  localparam int unsigned SUM_W   = 2 * CHAN_W;
  // a row-major index needs at most 2*COORD_W bits
  localparam int unsigned PROD_W  = 2 * COORD_W;

  localparam logic [PIXEL_W-1:0] PIXEL_WHITE = '1;
  localparam logic [CHAN_W-1:0]  ALPHA_FULL  = '1;
  localparam logic [ADDR_W-1:0]  ADDR_LAST   = ADDR_W'(PIX_COUNT - 1);

  localparam logic KIND_BLEND = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CALC,
    S_WB
  } state_e;

  // floor(n / 255), exact for any n up to 65279, which covers every mix_sum result
  function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] n);
    logic [SUM_W:0] t;
    t = {1'b0, n} + {{(CHAN_W+1){1'b0}}, n[SUM_W-1:CHAN_W]} + {{SUM_W{1'b0}}, 1'b1};
    return t[SUM_W-1:CHAN_W];
  endfunction

  function automatic logic [SUM_W-1:0] mix_sum(input logic [CHAN_W-1:0] s,
                                               input logic [CHAN_W-1:0] d,
                                               input logic [CHAN_W-1:0] a);
    logic [SUM_W-1:0] ps;
    logic [SUM_W-1:0] pd;
    ps = SUM_W'(s) * SUM_W'(a);
    pd = SUM_W'(d) * SUM_W'(ALPHA_FULL - a);
    return ps + pd;
  endfunction

endpackage

/* rtl/coverage_blend_framebuffer.sv */
// Channel   Handshake                  Payload
// in        in_valid_i / in_stall_o    kind_i, pos_x_i, pos_y_i, coverage_i
// out       out_valid_o / out_stall_i  pixel_red_o, pixel_green_o, pixel_blue_o, clipped_o
// cfg       cfg_valid_i / cfg_ready_o  cfg_data_i (source_color)
//
// Items are handled one at a time: accept, frame store read, multiply, divide and
// write back. The read/modify/write of the frame store keeps one item in flight.
// After reset a clearing pass writes white to all 307200 pixels, one per
// cycle; in_stall_o stays high for those cycles. Config writes are always taken.
// A result waits in the output register; while it is stalled the next item
// may be accepted and is held in write back until the register frees up.
module coverage_blend_framebuffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic signed [cbf_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [cbf_pkg::POS_W-1:0] pos_y_i,
  input  logic [cbf_pkg::CHAN_W-1:0]    coverage_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cbf_pkg::CHAN_W-1:0]    pixel_red_o,
  output logic [cbf_pkg::CHAN_W-1:0]    pixel_green_o,
  output logic [cbf_pkg::CHAN_W-1:0]    pixel_blue_o,
  output logic                          clipped_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cbf_pkg::PIXEL_W-1:0]   cfg_data_i
);

  import cbf_pkg::*;

  state_e state_q, state_d;

  logic [ADDR_W-1:0]  clr_cnt_q;
  logic [PIXEL_W-1:0] source_color_q;

  logic               kind_q;
  logic               clip_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [CHAN_W-1:0]  cov_q;
  logic [PIXEL_W-1:0] pix_q;
  logic [SUM_W-1:0]   sum_r_q, sum_g_q, sum_b_q;

  logic               out_valid_q;
  logic [PIXEL_W-1:0] out_pix_q;
  logic               out_clip_q;

  logic               in_take;
  logic               out_free;
  logic               out_load;
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [PIXEL_W-1:0] ram_wdata;
  logic [PIXEL_W-1:0] ram_rdata;

  logic               in_clip;
  logic [PROD_W-1:0]  in_index;
  logic [PIXEL_W-1:0] blend_pix;
  logic [PIXEL_W-1:0] result_pix;

  // clipping and row-major address of the incoming item
  always_comb begin
    in_clip = pos_x_i[POS_W-1] || pos_y_i[POS_W-1]
           || (pos_x_i[COORD_W-1:0] >= COORD_W'(FRAME_WIDTH))
           || (pos_y_i[COORD_W-1:0] >= COORD_W'(FRAME_HEIGHT));
    in_index = PROD_W'(pos_y_i[COORD_W-1:0]) * PROD_W'(FRAME_WIDTH)
             + PROD_W'(pos_x_i[COORD_W-1:0]);
  end

  always_comb begin
    blend_pix = {div255(sum_r_q), div255(sum_g_q), div255(sum_b_q)};
    result_pix = (kind_q == KIND_READ) ? pix_q : blend_pix;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_cnt_q == ADDR_LAST) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = S_CALC;
      S_CALC:  state_d = S_WB;
      S_WB:    if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = blend_pix;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = PIXEL_WHITE;
      end
      S_IDLE: in_stall_o = 1'b0;
      S_READ: ram_re = !clip_q;
      S_CALC: ;
      S_WB: begin
        out_load = out_free;
        ram_we   = out_free && !clip_q && (kind_q == KIND_BLEND);
      end
      default: ;
    endcase
  end

  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_cnt_q      <= '0;
      source_color_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        source_color_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q <= kind_i;
      clip_q <= in_clip;
      addr_q <= in_index[ADDR_W-1:0];
      cov_q  <= coverage_i;
    end
    if (state_q == S_CALC) begin
      pix_q   <= ram_rdata;
      sum_r_q <= mix_sum(source_color_q[3*CHAN_W-1:2*CHAN_W],
                         ram_rdata[3*CHAN_W-1:2*CHAN_W], cov_q);
      sum_g_q <= mix_sum(source_color_q[2*CHAN_W-1:CHAN_W],
                         ram_rdata[2*CHAN_W-1:CHAN_W], cov_q);
      sum_b_q <= mix_sum(source_color_q[CHAN_W-1:0], ram_rdata[CHAN_W-1:0], cov_q);
    end
    if (out_load) begin
      out_pix_q  <= clip_q ? '0 : result_pix;
      out_clip_q <= clip_q;
    end
  end

  cbf_ram #(
    .Width (PIXEL_W),
    .Depth (PIX_COUNT)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_red_o   = out_pix_q[3*CHAN_W-1:2*CHAN_W];
  assign pixel_green_o = out_pix_q[2*CHAN_W-1:CHAN_W];
  assign pixel_blue_o  = out_pix_q[CHAN_W-1:0];
  assign clipped_o     = out_clip_q;

endmodule

/* rtl/cbf_ram.sv */
module cbf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* verif/cbf_checker.sv */
`timescale 1ns / 1ps

module cbf_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            kind_i,
  input  logic signed [cbf_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [cbf_pkg::POS_W-1:0] pos_y_i,
  input  logic [cbf_pkg::CHAN_W-1:0]      coverage_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [cbf_pkg::CHAN_W-1:0]      pixel_red_i,
  input  logic [cbf_pkg::CHAN_W-1:0]      pixel_green_i,
  input  logic [cbf_pkg::CHAN_W-1:0]      pixel_blue_i,
  input  logic                            clipped_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [cbf_pkg::PIXEL_W-1:0]     cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o,
  output int                              clipped_seen_o
);
  import cbf_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              clipped;
  } pixel_result_t;

  // sparse copy of the frame; missing entries are still white
  logic [PIXEL_W-1:0] frame_copy [int];
  logic [PIXEL_W-1:0] source_color;
  pixel_result_t      expected_pixels [$];
  int                 fails;
  int                 checked;
  int                 clipped_seen;

  function automatic logic [CHAN_W-1:0] blend_channel(input logic [CHAN_W-1:0] s,
                                                      input logic [CHAN_W-1:0] d,
                                                      input logic [CHAN_W-1:0] a);
    int full;
    int sum;
    full = int'(ALPHA_FULL);
    sum  = int'(s) * int'(a) + int'(d) * (full - int'(a));
    return CHAN_W'(sum / full);
  endfunction

  function automatic pixel_result_t predict_pixel(input logic k,
                                                  input logic signed [POS_W-1:0] x,
                                                  input logic signed [POS_W-1:0] y,
                                                  input logic [CHAN_W-1:0] a);
    int                 xi;
    int                 yi;
    int                 idx;
    logic [PIXEL_W-1:0] px;
    pixel_result_t      r;
    xi = int'(x);
    yi = int'(y);
    r  = '0;
    if (xi < 0 || yi < 0 || xi >= int'(FRAME_WIDTH) || yi >= int'(FRAME_HEIGHT)) begin
      r.clipped = 1'b1;
      return r;
    end
    idx = yi * int'(FRAME_WIDTH) + xi;
    px  = frame_copy.exists(idx) ? frame_copy[idx] : PIXEL_WHITE;
    if (k == KIND_BLEND) begin
      px = {blend_channel(source_color[23:16], px[23:16], a),
            blend_channel(source_color[15:8],  px[15:8],  a),
            blend_channel(source_color[7:0],   px[7:0],   a)};
      frame_copy[idx] = px;
    end
    r.red   = px[23:16];
    r.green = px[15:8];
    r.blue  = px[7:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_result_t got;
    pixel_result_t want;
    if (!rst_ni) begin
      frame_copy.delete();
      expected_pixels.delete();
      source_color = '0;
      fails        = 0;
      checked      = 0;
      clipped_seen = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i)
        source_color = cfg_data_i;
      // a result always belongs to an item accepted earlier, so compare before predicting
      if (out_valid_i && !out_stall_i) begin
        got = {pixel_red_i, pixel_green_i, pixel_blue_i, clipped_i};
        if (expected_pixels.size() == 0) begin
          $error("result with no item pending: %h", got);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          checked++;
          if (want.clipped)
            clipped_seen++;
          if (got.red !== want.red) begin
            $error("pixel_red: expected %0d, got %0d", want.red, got.red);
            fails++;
          end
          if (got.green !== want.green) begin
            $error("pixel_green: expected %0d, got %0d", want.green, got.green);
            fails++;
          end
          if (got.blue !== want.blue) begin
            $error("pixel_blue: expected %0d, got %0d", want.blue, got.blue);
            fails++;
          end
          if (got.clipped !== want.clipped) begin
            $error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_pixels.push_back(predict_pixel(kind_i, pos_x_i, pos_y_i, coverage_i));
    end
    fail_count_o   <= fails;
    pending_o      <= expected_pixels.size();
    checked_o      <= checked;
    clipped_seen_o <= clipped_seen;
  end

endmodule

/* verif/tb_coverage_blend_framebuffer.sv */
`timescale 1ns / 1ps

module tb_coverage_blend_framebuffer;
  import cbf_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic                      kind        = KIND_BLEND;
  logic signed [POS_W-1:0]   pos_x       = '0;
  logic signed [POS_W-1:0]   pos_y       = '0;
  logic [CHAN_W-1:0]         coverage    = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic [CHAN_W-1:0]         pixel_red;
  logic [CHAN_W-1:0]         pixel_green;
  logic [CHAN_W-1:0]         pixel_blue;
  logic                      clipped;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [PIXEL_W-1:0]        cfg_data    = '0;

  int fail_count;
  int pending;
  int checked;
  int clipped_seen;
  int colors_used = 0;
  bit no_idle     = 1'b0;
  bit hold_req    = 1'b0;

  always #6 clk_i = ~clk_i;

  coverage_blend_framebuffer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .coverage_i    (coverage),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_red_o   (pixel_red),
    .pixel_green_o (pixel_green),
    .pixel_blue_o  (pixel_blue),
    .clipped_o     (clipped),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  cbf_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .kind_i         (kind),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .coverage_i     (coverage),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_red_i    (pixel_red),
    .pixel_green_i  (pixel_green),
    .pixel_blue_i   (pixel_blue),
    .clipped_i      (clipped),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .clipped_seen_o (clipped_seen)
  );

  task automatic send_item(input logic k, input logic signed [POS_W-1:0] x,
                           input logic signed [POS_W-1:0] y, input logic [CHAN_W-1:0] a);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= k;
    pos_x    <= x;
    pos_y    <= y;
    coverage <= a;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic write_source(input logic [PIXEL_W-1:0] color);
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    colors_used++;
  endtask

  // stop offering items and let every outstanding pixel come back
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic random_item();
    int                      sel;
    logic                    k;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [CHAN_W-1:0]       a;
    sel = $urandom_range(0, 99);
    k   = ($urandom_range(0, 3) == 0) ? KIND_READ : KIND_BLEND;
    if (sel < 45) begin
      // small hot tile: repeated hits on the same pixels
      x = POS_W'($urandom_range(0, 7));
      y = POS_W'($urandom_range(0, 3));
    end else if (sel < 75) begin
      x = POS_W'($urandom_range(0, FRAME_WIDTH - 1));
      y = POS_W'($urandom_range(0, FRAME_HEIGHT - 1));
    end else if (sel < 85) begin
      case ($urandom_range(0, 3))
        0:       x = POS_W'(0);
        1:       x = POS_W'(FRAME_WIDTH - 1);
        2:       x = POS_W'(FRAME_WIDTH);
        default: x = POS_W'(-1);
      endcase
      case ($urandom_range(0, 3))
        0:       y = POS_W'(0);
        1:       y = POS_W'(FRAME_HEIGHT - 1);
        2:       y = POS_W'(FRAME_HEIGHT);
        default: y = POS_W'(-1);
      endcase
    end else begin
      x = POS_W'($urandom);
      y = POS_W'($urandom);
    end
    case ($urandom_range(0, 9))
      0:       a = '0;
      1:       a = ALPHA_FULL;
      default: a = CHAN_W'($urandom);
    endcase
    send_item(k, x, y, a);
  endtask

  // receiver: random stall per result, one long hold on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 4);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("tb_coverage_blend_framebuffer NOT OK");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: black source over the white frame
    write_source('0);
    send_item(KIND_READ,  POS_W'(0), POS_W'(0), 8'h5A);
    send_item(KIND_READ,  POS_W'(FRAME_WIDTH - 1), POS_W'(FRAME_HEIGHT - 1), 8'h00);
    send_item(KIND_BLEND, POS_W'(0), POS_W'(0), 8'd0);
    send_item(KIND_BLEND, POS_W'(0), POS_W'(0), ALPHA_FULL);
    send_item(KIND_BLEND, POS_W'(1), POS_W'(0), 8'd128);
    send_item(KIND_BLEND, POS_W'(1), POS_W'(0), 8'd1);
    send_item(KIND_BLEND, POS_W'(1), POS_W'(0), 8'd254);
    send_item(KIND_READ,  POS_W'(1), POS_W'(0), ALPHA_FULL);
    send_item(KIND_BLEND, POS_W'(FRAME_WIDTH - 1), POS_W'(FRAME_HEIGHT - 1), ALPHA_FULL);
    send_item(KIND_READ,  POS_W'(FRAME_WIDTH - 1), POS_W'(FRAME_HEIGHT - 1), 8'd3);
    send_item(KIND_BLEND, POS_W'(FRAME_WIDTH - 1), POS_W'(0), 8'd77);
    send_item(KIND_BLEND, POS_W'(0), POS_W'(FRAME_HEIGHT - 1), 8'd200);
    // clipped positions, both kinds
    send_item(KIND_BLEND, POS_W'(-1), POS_W'(0), ALPHA_FULL);
    send_item(KIND_READ,  POS_W'(0), POS_W'(-1), 8'd9);
    send_item(KIND_BLEND, POS_W'(FRAME_WIDTH), POS_W'(5), 8'd128);
    send_item(KIND_READ,  POS_W'(3), POS_W'(FRAME_HEIGHT), 8'd0);
    send_item(KIND_BLEND, POS_W'(-1024), POS_W'(-1024), ALPHA_FULL);
    send_item(KIND_READ,  POS_W'(1023), POS_W'(1023), ALPHA_FULL);
    send_item(KIND_BLEND, POS_W'(1023), POS_W'(0), ALPHA_FULL);
    send_item(KIND_READ,  POS_W'(-1024), POS_W'(1023), 8'd64);
    send_item(KIND_READ,  POS_W'(0), POS_W'(0), 8'd0);
    drain_pixels();

    write_source('1);
    repeat (300) random_item();
    drain_pixels();

    write_source(PIXEL_W'($urandom));
    no_idle = 1'b1;
    for (int i = 0; i < 350; i++) begin
      if (i == 150)
        no_idle = 1'b0;
      random_item();
    end
    drain_pixels();

    write_source(PIXEL_W'($urandom));
    for (int i = 0; i < 350; i++) begin
      if (i == 40)
        hold_req = 1'b1;
      random_item();
    end
    drain_pixels();

    write_source(24'h00FF00);
    repeat (350) random_item();

    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && pending != 0; i++)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending != 0)
      $error("%0d results never arrived", pending);

    $display("checked %0d pixel results (%0d clipped) under %0d source colors,",
             checked, clipped_seen, colors_used);
    $display("with random stalls, a no-gap stretch and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_coverage_blend_framebuffer OK");
    end else begin
      $display("tb_coverage_blend_framebuffer NOT OK");
    end
    $finish;
  end

endmodule
